// File: hdl/sfd_pkg.sv
// shared types and constants for the sprite framebuffer draw block
`default_nettype none
package sfd_pkg;

	// screen geometry
	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 32;

	// index widths for columns and rows
	localparam int COL_AW = $clog2(SCREEN_WIDTH);
	localparam int ROW_AW = $clog2(SCREEN_HEIGHT);

	// payload widths fixed by the item format
	localparam int MODE_W   = 3;
	localparam int POS_W    = 8;
	localparam int SPRITE_W = 8;

	// sprite mask before clipping to the screen width
	localparam int MASK_W = SCREEN_WIDTH + SPRITE_W;

	// operation codes
	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR_SCREEN = 3'd0,
		MODE_DRAW_ROW     = 3'd1,
		MODE_READ_PIXEL   = 3'd2,
		MODE_SET_PIXEL    = 3'd3,
		MODE_CLEAR_PIXEL  = 3'd4
	} mode_t;

	// one command as held in the input register
	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [POS_W-1:0]    x_pos;
		logic [POS_W-1:0]    y_pos;
		logic [SPRITE_W-1:0] sprite_row;
		logic                last_row;
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic in_bounds;
		logic pixel_value;
		logic collision;
	} result_t;

endpackage
`default_nettype wire

// File: hdl/sfd_if.sv
// valid/ready channel interfaces for commands and results
`default_nettype none
interface sfd_item_if;
	logic                         valid;
	logic                         ready;
	logic [sfd_pkg::MODE_W-1:0]   mode;
	logic [sfd_pkg::POS_W-1:0]    x_pos;
	logic [sfd_pkg::POS_W-1:0]    y_pos;
	logic [sfd_pkg::SPRITE_W-1:0] sprite_row;
	logic                         last_row;

	modport source (output valid, mode, x_pos, y_pos, sprite_row, last_row, input ready);
	modport sink (input valid, mode, x_pos, y_pos, sprite_row, last_row, output ready);
endinterface

interface sfd_result_if;
	logic valid;
	logic ready;
	logic in_bounds;
	logic pixel_value;
	logic collision;

	modport source (output valid, in_bounds, pixel_value, collision, input ready);
	modport sink (input valid, in_bounds, pixel_value, collision, output ready);
endinterface
`default_nettype wire

// File: hdl/sfd_frame.sv
// framebuffer register file with row-wide xor draw and single-pixel access
`default_nettype none
module sfd_frame (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire sfd_pkg::cmd_t    cmd,
	output sfd_pkg::result_t      res
);

	logic [sfd_pkg::SCREEN_WIDTH-1:0] frame_q [sfd_pkg::SCREEN_HEIGHT];
	logic                             hit_acc_q;

	logic [sfd_pkg::ROW_AW-1:0]       row_idx;
	logic [sfd_pkg::COL_AW-1:0]       col_idx;
	logic                             x_ok;
	logic                             y_ok;
	logic                             inb;
	logic [sfd_pkg::SCREEN_WIDTH-1:0] row_data;
	logic [sfd_pkg::SPRITE_W-1:0]     sprite_rev;
	logic [sfd_pkg::MASK_W-1:0]       mask_wide;
	logic [sfd_pkg::SCREEN_WIDTH-1:0] sprite_mask;
	logic [sfd_pkg::SCREEN_WIDTH-1:0] pix_mask;
	logic [sfd_pkg::SCREEN_WIDTH-1:0] row_next;
	logic                             row_we;
	logic                             clear_all;
	logic                             hit;
	logic                             collide;
	logic                             acc_we;

	// bounds and row fetch
	always_comb begin
		row_idx  = cmd.y_pos[sfd_pkg::ROW_AW-1:0];
		col_idx  = cmd.x_pos[sfd_pkg::COL_AW-1:0];
		x_ok     = cmd.x_pos < sfd_pkg::POS_W'(sfd_pkg::SCREEN_WIDTH);
		y_ok     = cmd.y_pos < sfd_pkg::POS_W'(sfd_pkg::SCREEN_HEIGHT);
		inb      = x_ok && y_ok;
		row_data = y_ok ? frame_q[row_idx] : '0;
	end

	// sprite mask: leftmost sprite pixel lands on column x_pos, clipped at the right edge
	always_comb begin
		for (int i = 0; i < sfd_pkg::SPRITE_W; i++) begin
			sprite_rev[i] = cmd.sprite_row[sfd_pkg::SPRITE_W-1-i];
		end
		mask_wide   = sfd_pkg::MASK_W'(sprite_rev) << cmd.x_pos;
		sprite_mask = mask_wide[sfd_pkg::SCREEN_WIDTH-1:0];
		pix_mask    = sfd_pkg::SCREEN_WIDTH'(1) << cmd.x_pos;
		hit         = |(row_data & sprite_mask);
		collide     = hit || hit_acc_q;
	end

	// operation decode
	always_comb begin
		row_next  = row_data;
		row_we    = 1'b0;
		clear_all = 1'b0;
		acc_we    = 1'b0;
		res       = '0;
		unique case (cmd.mode)
			sfd_pkg::MODE_CLEAR_SCREEN: begin
				clear_all     = 1'b1;
				res.in_bounds = 1'b1;
			end
			sfd_pkg::MODE_DRAW_ROW: begin
				row_next      = row_data ^ sprite_mask;
				row_we        = y_ok;
				acc_we        = 1'b1;
				res.in_bounds = inb;
				res.collision = collide;
			end
			sfd_pkg::MODE_READ_PIXEL: begin
				res.in_bounds   = inb;
				res.pixel_value = inb && row_data[col_idx];
			end
			sfd_pkg::MODE_SET_PIXEL: begin
				row_next      = row_data | pix_mask;
				row_we        = inb;
				res.in_bounds = inb;
			end
			sfd_pkg::MODE_CLEAR_PIXEL: begin
				row_next      = row_data & ~pix_mask;
				row_we        = inb;
				res.in_bounds = inb;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// framebuffer update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < sfd_pkg::SCREEN_HEIGHT; r++) begin
				frame_q[r] <= '0;
			end
		end else if (en) begin
			if (clear_all) begin
				for (int r = 0; r < sfd_pkg::SCREEN_HEIGHT; r++) begin
					frame_q[r] <= '0;
				end
			end else if (row_we) begin
				frame_q[row_idx] <= row_next;
			end
		end
	end

	// collision accumulator over the rows of one sprite
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_acc_q <= 1'b0;
		end else if (en && acc_we) begin
			hit_acc_q <= cmd.last_row ? 1'b0 : collide;
		end
	end

endmodule
`default_nettype wire

// File: hdl/sprite_framebuffer_draw.sv
// top level: input register, framebuffer operation, result register
`default_nettype none
// One-bit 64x32 framebuffer with clear-screen, xor sprite-row draw and
// single-pixel read/set/clear; pixels off the screen are clipped. Each
// command is held in an input register, carried out against the register
// framebuffer (a whole row is read, modified and written back)
// and its result is held in an output register. One command is accepted per
// clock while the result side keeps up; a result beat is offered once its
// command has passed the input register and the result register. The
// framebuffer and the collision accumulator are cleared by reset.
module sprite_framebuffer_draw (
	input wire logic      clk,
	input wire logic      arst_n,
	sfd_item_if.sink      item,
	sfd_result_if.source  result
);

	sfd_pkg::cmd_t    cmd_s1;
	logic             valid_s1;
	sfd_pkg::result_t res_comb;
	sfd_pkg::result_t res_s2;
	logic             valid_s2;
	logic             advance;
	logic             take;

	// handshake control
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take       = item.valid && item.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.mode       <= item.mode;
			cmd_s1.x_pos      <= item.x_pos;
			cmd_s1.y_pos      <= item.y_pos;
			cmd_s1.sprite_row <= item.sprite_row;
			cmd_s1.last_row   <= item.last_row;
		end
	end

	// framebuffer and operation logic
	sfd_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cmd    (cmd_s1),
		.res    (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	// result beat
	assign result.valid       = valid_s2;
	assign result.in_bounds   = res_s2.in_bounds;
	assign result.pixel_value = res_s2.pixel_value;
	assign result.collision   = res_s2.collision;

endmodule
`default_nettype wire
